// ===== rtl/core/bvl_pkg.sv =====
`default_nettype none

package bvl_pkg;

    localparam int WORD_W            = 32;
    localparam int POS_W             = 6;
    localparam int COUNT_W           = 7;
    localparam int ACTION_W          = 2;
    localparam int STATUS_W          = 3;
    localparam int IN_DATA_W         = 104;
    localparam int OUT_DATA_W        = 104;
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int ENTRY_W           = 3 * WORD_W;

    localparam logic [WORD_W-1:0] MEM_FIELD_MASK_RST = 32'h0000_00FF;

    localparam logic [ACTION_W-1:0] ACT_VALIDATE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR     = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ      = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_READ_ALT  = 2'd3;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED      = 3'd0,
        ST_MERGED     = 3'd1,
        ST_PLACE_CONF = 3'd2,
        ST_FLAG_CONF  = 3'd3,
        ST_FULL       = 3'd4,
        ST_RESET      = 3'd5,
        ST_READ_OK    = 3'd6,
        ST_READ_END   = 3'd7
    } t_status;

    typedef struct packed {
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] flags;
        logic [WORD_W-1:0] handle;
    } t_entry;

    typedef struct packed {
        logic              hit;
        t_status           status;
        logic [WORD_W-1:0] flags;
        logic [WORD_W-1:0] mask;
    } t_merge_res;

endpackage

`default_nettype wire

// ===== rtl/core/bvl_ram.sv =====
`default_nettype none

module bvl_ram #(
    parameter int WIDTH = bvl_pkg::ENTRY_W,
    parameter int DEPTH = bvl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/core/bvl_merge.sv =====
`default_nettype none

module bvl_merge (
    input  logic [bvl_pkg::WORD_W-1:0] i_req_handle,
    input  logic [bvl_pkg::WORD_W-1:0] i_req_flags,
    input  logic [bvl_pkg::WORD_W-1:0] i_req_mask,
    input  bvl_pkg::t_entry            i_entry,
    input  logic [bvl_pkg::WORD_W-1:0] i_mem_mask,
    output bvl_pkg::t_merge_res        o_res
);

    import bvl_pkg::*;

    logic [WORD_W-1:0] w_mem_sel;
    logic [WORD_W-1:0] w_mem_flags;
    logic [WORD_W-1:0] w_new_mask;
    logic [WORD_W-1:0] w_disagree;

    assign w_mem_sel   = (i_entry.mask | i_req_mask) & i_mem_mask;
    assign w_mem_flags = i_entry.flags & i_req_flags & w_mem_sel;
    assign w_new_mask  = i_entry.mask | i_req_mask;
    assign w_disagree  = i_req_mask & i_entry.mask & ~i_mem_mask
                         & (i_entry.flags ^ i_req_flags);

    always_comb begin
        o_res.hit   = (i_entry.handle == i_req_handle);
        o_res.flags = i_entry.flags;
        o_res.mask  = i_entry.mask;
        if (w_mem_flags == '0) begin
            o_res.status = ST_PLACE_CONF;
        end else if (w_disagree != '0) begin
            o_res.status = ST_FLAG_CONF;
        end else begin
            o_res.status = ST_MERGED;
            o_res.flags  = w_mem_flags
                           | ((i_entry.flags | i_req_flags) & w_new_mask & ~i_mem_mask);
            o_res.mask   = w_new_mask;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/buffer_validate_list_top.sv =====
// Validate compares one stored handle per cycle through the single table read port, stopping
//   at the first matching entry or after the last stored entry; read and table reset each
//   return one result beat.
// Throughput: one beat at a time; s_axis_tready returns in the same cycle that the result is
//   registered; an untaken result stalls.
// Reset: synchronous, active low; empties the table and sets memory_field_mask to 0xFF.
`default_nettype none

module buffer_validate_list_top #(
    parameter int TABLE_ENTRIES = bvl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // buffer_handle[31:0], placement_flags[63:32], flag_mask[95:64], read_position[101:96]
    input  logic [bvl_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    // action[1:0]
    input  logic [bvl_pkg::ACTION_W-1:0]         s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // handle_out[31:0], flags_out[63:32], mask_out[95:64], entry_count[102:96]
    output logic [bvl_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // status[2:0]
    output logic [bvl_pkg::STATUS_W-1:0]         m_axis_tuser,
    input  logic                                 i_cfg_wr_en,
    input  logic [bvl_pkg::WORD_W-1:0]           i_cfg_wr_data
);

    import bvl_pkg::*;

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CMP_W = CNT_W + POS_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_RDREQ  = 5'b00100,
        S_RDWAIT = 5'b01000,
        S_OUT    = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]  r_rd_idx, n_rd_idx;
    logic [WORD_W-1:0] r_mem_mask;

    logic [WORD_W-1:0] r_handle, n_handle;
    logic [WORD_W-1:0] r_flags, n_flags;
    logic [WORD_W-1:0] r_mask, n_mask;
    logic [POS_W-1:0]  r_pos, n_pos;

    t_status           r_res_status, n_res_status;
    logic [WORD_W-1:0] r_res_handle, n_res_handle;
    logic [WORD_W-1:0] r_res_flags, n_res_flags;
    logic [WORD_W-1:0] r_res_mask, n_res_mask;

    logic              r_out_valid;
    t_status           r_out_status;
    logic [WORD_W-1:0] r_out_handle;
    logic [WORD_W-1:0] r_out_flags;
    logic [WORD_W-1:0] r_out_mask;
    logic [COUNT_W-1:0] r_out_count;

    logic              w_in_fire;
    logic              w_out_free;
    logic              w_hit;
    logic              w_scan_end;
    logic              w_pos_ok;
    logic [CMP_W-1:0]  w_slot_full;
    logic [IDX_W-1:0]  w_slot;
    t_merge_res        w_merge;
    t_entry            w_rd_entry;
    t_entry            w_wr_entry;
    logic [ENTRY_W-1:0] w_rd_data;

    logic              ram_wr_en;
    logic [IDX_W-1:0]  ram_wr_addr;
    logic              ram_rd_en;
    logic [IDX_W-1:0]  ram_rd_addr;

    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_rd_entry    = t_entry'(w_rd_data);

    assign w_hit      = r_rd_vld && w_merge.hit;
    assign w_scan_end = (r_count == '0)
                        || (r_rd_vld && (CNT_W'(r_rd_idx) == r_count - CNT_W'(1)));
    assign w_pos_ok    = CMP_W'(r_pos) < CMP_W'(r_count);
    assign w_slot_full = CMP_W'(r_count) - CMP_W'(1) - CMP_W'(r_pos);
    assign w_slot      = w_slot_full[IDX_W-1:0];

    bvl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (w_wr_entry),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (w_rd_data)
    );

    bvl_merge u_merge (
        .i_req_handle (r_handle),
        .i_req_flags  (r_flags),
        .i_req_mask   (r_mask),
        .i_entry      (w_rd_entry),
        .i_mem_mask   (r_mem_mask),
        .o_res        (w_merge)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_rd_vld     = 1'b0;
        n_rd_idx     = r_rd_idx;
        n_handle     = r_handle;
        n_flags      = r_flags;
        n_mask       = r_mask;
        n_pos        = r_pos;
        n_res_status = r_res_status;
        n_res_handle = r_res_handle;
        n_res_flags  = r_res_flags;
        n_res_mask   = r_res_mask;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_rd_idx;
        w_wr_entry   = '{mask: w_merge.mask, flags: w_merge.flags, handle: r_handle};
        ram_rd_en    = 1'b0;
        ram_rd_addr  = r_idx[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_handle = s_axis_tdata[31:0];
                    n_flags  = s_axis_tdata[63:32];
                    n_mask   = s_axis_tdata[95:64];
                    n_pos    = s_axis_tdata[101:96];
                    unique case (s_axis_tuser) inside
                        ACT_VALIDATE: begin
                            n_idx   = '0;
                            n_state = S_SCAN;
                        end
                        ACT_CLEAR: begin
                            n_count      = '0;
                            n_res_status = ST_RESET;
                            n_res_handle = '0;
                            n_res_flags  = '0;
                            n_res_mask   = '0;
                            n_state      = S_OUT;
                        end
                        ACT_READ, ACT_READ_ALT: begin
                            n_state = S_RDREQ;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_res_status = w_merge.status;
                    n_res_handle = r_handle;
                    n_res_flags  = w_merge.flags;
                    n_res_mask   = w_merge.mask;
                    ram_wr_en    = (w_merge.status == ST_MERGED);
                    n_state      = S_OUT;
                end else if (w_scan_end) begin
                    n_res_handle = r_handle;
                    if (r_count == CNT_W'(TABLE_ENTRIES)) begin
                        n_res_status = ST_FULL;
                        n_res_flags  = '0;
                        n_res_mask   = '0;
                    end else begin
                        ram_wr_en    = 1'b1;
                        ram_wr_addr  = r_count[IDX_W-1:0];
                        w_wr_entry   = '{mask: r_mask, flags: r_flags, handle: r_handle};
                        n_count      = r_count + CNT_W'(1);
                        n_res_status = ST_ADDED;
                        n_res_flags  = r_flags;
                        n_res_mask   = r_mask;
                    end
                    n_state = S_OUT;
                end else if (r_idx < r_count) begin
                    ram_rd_en = 1'b1;
                    n_idx     = r_idx + CNT_W'(1);
                    n_rd_vld  = 1'b1;
                    n_rd_idx  = r_idx[IDX_W-1:0];
                end
            end
            S_RDREQ: begin
                if (w_pos_ok) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = w_slot;
                    n_state     = S_RDWAIT;
                end else begin
                    n_res_status = ST_READ_END;
                    n_res_handle = '0;
                    n_res_flags  = '0;
                    n_res_mask   = '0;
                    n_state      = S_OUT;
                end
            end
            S_RDWAIT: begin
                n_res_status = ST_READ_OK;
                n_res_handle = w_rd_entry.handle;
                n_res_flags  = w_rd_entry.flags;
                n_res_mask   = w_rd_entry.mask;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_idx      <= '0;
            r_rd_vld   <= 1'b0;
            r_mem_mask <= MEM_FIELD_MASK_RST;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_rd_vld <= n_rd_vld;
            if (i_cfg_wr_en) begin
                r_mem_mask <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx     <= n_rd_idx;
        r_handle     <= n_handle;
        r_flags      <= n_flags;
        r_mask       <= n_mask;
        r_pos        <= n_pos;
        r_res_status <= n_res_status;
        r_res_handle <= n_res_handle;
        r_res_flags  <= n_res_flags;
        r_res_mask   <= n_res_mask;
    end

    // hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_out_status <= r_res_status;
            r_out_handle <= r_res_handle;
            r_out_flags  <= r_res_flags;
            r_out_mask   <= r_res_mask;
            r_out_count  <= COUNT_W'(r_count);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {1'b0, r_out_count, r_out_mask, r_out_flags, r_out_handle};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count above table size");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_RESET |-> m_axis_tdata[102:96] == '0)
        else $error("reset beat with nonzero count");

    a_added_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_ADDED |-> m_axis_tdata[102:96] != '0)
        else $error("added beat with empty table");

    a_write_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_wr_en |-> r_state == S_SCAN && !ram_rd_en)
        else $error("table write outside scan");

endmodule

`default_nettype wire
